// ----- sv/sftc_pkg.sv -----
// Shared types and constants for the SPI framed transaction checker.
// No dependencies; imported by sftc_core and spi_framed_transaction_checker.
package sftc_pkg;

    // Item kinds on the input channel
    localparam logic [2:0] KIND_WRITE     = 3'd0;
    localparam logic [2:0] KIND_HDR_REPLY = 3'd1;
    localparam logic [2:0] KIND_RD_START  = 3'd2;
    localparam logic [2:0] KIND_RD_BYTE   = 3'd3;
    localparam logic [2:0] KIND_ACK_REPLY = 3'd4;
    localparam logic [2:0] KIND_RESET     = 3'd5;

    // Verdict codes
    localparam logic [3:0] ST_CONTINUE  = 4'd0;
    localparam logic [3:0] ST_OK        = 4'd1;
    localparam logic [3:0] ST_HDR_CHK   = 4'd2;
    localparam logic [3:0] ST_HDR_REPLY = 4'd3;
    localparam logic [3:0] ST_LEN       = 4'd4;
    localparam logic [3:0] ST_DATA_CHK  = 4'd5;
    localparam logic [3:0] ST_BUSY      = 4'd6;
    localparam logic [3:0] ST_SMALL     = 4'd7;
    localparam logic [3:0] ST_NACK      = 4'd8;
    localparam logic [3:0] ST_START     = 4'd9;
    localparam logic [3:0] ST_RESP_LEN  = 4'd10;
    localparam logic [3:0] ST_RESP_CHK  = 4'd11;
    localparam logic [3:0] ST_ACK_FAIL  = 4'd12;
    localparam logic [3:0] ST_WAIT_HDR  = 4'd13;
    localparam logic [3:0] ST_WAIT_ACK  = 4'd14;

    // Protocol bytes
    localparam logic [7:0] XOR_SEED   = 8'hAB;
    localparam logic [7:0] HDR_START  = 8'h5A;
    localparam logic [7:0] HDR_ACK    = 8'h79;
    localparam logic [7:0] RESP_START = 8'h85;
    localparam logic [7:0] RESP_NACK  = 8'h1F;

    // Configuration register map
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_EXPECTED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_RETRY    = 2'd2;
    localparam logic [9:0] RETRY_MAX       = 10'd1000;
    localparam logic [7:0] ACK_EXPECTED_RST = 8'h06;
    localparam logic [9:0] ACK_RETRY_RST    = 10'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WHDR,
        PH_WDATA,
        PH_WRAW,
        PH_HREPLY,
        PH_ACK,
        PH_READ
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [16:0] call_length;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic        done_res;
        logic [16:0] byte_count;
    } t_out_item;

    typedef struct packed {
        logic       ack_wait;
        logic [7:0] ack_expected;
        logic [9:0] ack_retry_limit;
    } t_cfg;

endpackage

// ----- sv/sftc_core.sv -----
// Transaction state and per-item verdict logic of the SPI framed checker.
// Depends on sftc_pkg. State advances only on i_fire; o_result is combinational.
module sftc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  sftc_pkg::t_in_item i_item,
    input  sftc_pkg::t_cfg     i_cfg,
    output sftc_pkg::t_out_item o_result
);
    import sftc_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_header_open, n_header_open;
    logic        r_resp_pending, n_resp_pending;
    logic [15:0] r_out_len, n_out_len;
    logic [15:0] r_back_len, n_back_len;
    logic [31:0] r_held, n_held;
    logic [16:0] r_pos, n_pos;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_frame_len, n_frame_len;
    logic [3:0]  r_err, n_err;
    logic [9:0]  r_retry, n_retry;
    logic [16:0] r_call_total, n_call_total;

    t_out_item   w_res;
    logic [16:0] w_need;
    logic        w_last;
    logic [7:0]  w_b;
    logic [16:0] w_len;

    assign w_b    = i_item.data_byte;
    assign w_len  = i_item.call_length;
    assign w_need = 17'd4 + {1'b0, r_back_len};

    always_comb begin
        n_phase        = r_phase;
        n_header_open  = r_header_open;
        n_resp_pending = r_resp_pending;
        n_out_len      = r_out_len;
        n_back_len     = r_back_len;
        n_held         = r_held;
        n_pos          = r_pos;
        n_xor          = r_xor;
        n_frame_len    = r_frame_len;
        n_err          = r_err;
        n_retry        = r_retry;
        n_call_total   = r_call_total;
        w_res          = '{status: ST_CONTINUE, done_res: 1'b0, byte_count: 17'd0};
        w_last         = 1'b0;

        if (i_fire) begin
            unique case (i_item.kind)
                KIND_RESET: begin
                    n_phase        = PH_IDLE;
                    n_header_open  = 1'b0;
                    n_resp_pending = 1'b0;
                    n_out_len      = '0;
                    n_back_len     = '0;
                    n_held         = '0;
                    n_pos          = '0;
                    n_xor          = XOR_SEED;
                    n_frame_len    = '0;
                    n_err          = '0;
                    n_retry        = '0;
                    n_call_total   = '0;
                    w_res = '{status: ST_OK, done_res: 1'b1, byte_count: 17'd0};
                end
                KIND_WRITE: begin
                    // opening byte of a call picks the phase
                    if (r_phase == PH_IDLE) begin
                        if (w_len == 17'd0) begin
                            w_res = '{status: ST_OK, done_res: 1'b1, byte_count: 17'd0};
                        end else begin
                            n_call_total = w_len;
                            n_pos        = '0;
                            n_xor        = XOR_SEED;
                            n_err        = '0;
                            n_frame_len  = '0;
                            if (w_len == 17'd7 && w_b == HDR_START) begin
                                n_phase = PH_WHDR;
                                n_held  = '0;
                            end else if (r_header_open) begin
                                n_phase = PH_WDATA;
                                if (w_len != 17'd1 + {1'b0, r_out_len}) begin
                                    n_err = ST_LEN;
                                end
                            end else begin
                                n_phase = PH_WRAW;
                                if (r_resp_pending) begin
                                    n_err = ST_BUSY;
                                end
                            end
                        end
                    end
                    if (n_phase == PH_WHDR || n_phase == PH_WDATA || n_phase == PH_WRAW) begin
                        w_last = ({1'b0, n_pos} + 18'd1) == {1'b0, n_call_total};
                        if (n_phase == PH_WHDR) begin
                            if (n_pos < 17'd6) begin
                                n_xor = n_xor ^ w_b;
                            end
                            if (n_pos == 17'd2) n_held[7:0]   = n_held[7:0] | w_b;
                            if (n_pos == 17'd3) n_held[15:8]  = n_held[15:8] | w_b;
                            if (n_pos == 17'd4) n_held[23:16] = n_held[23:16] | w_b;
                            if (n_pos == 17'd5) n_held[31:24] = n_held[31:24] | w_b;
                            if (n_pos == 17'd6 && n_xor != w_b && n_err == 4'd0) begin
                                n_err = ST_HDR_CHK;
                            end
                        end else if (n_phase == PH_WDATA && n_err == 4'd0) begin
                            if (n_pos < {1'b0, r_out_len}) begin
                                n_xor = n_xor ^ w_b;
                            end else if (n_pos == {1'b0, r_out_len} && n_xor != w_b) begin
                                n_err = ST_DATA_CHK;
                            end
                        end
                        if (!w_last) begin
                            n_pos = n_pos + 17'd1;
                        end else if (n_phase == PH_WHDR) begin
                            if (n_err != 4'd0) begin
                                w_res   = '{status: n_err, done_res: 1'b1, byte_count: 17'd0};
                                n_phase = PH_IDLE;
                            end else begin
                                w_res   = '{status: ST_WAIT_HDR, done_res: 1'b0,
                                            byte_count: 17'd0};
                                n_phase = PH_HREPLY;
                            end
                        end else if (n_phase == PH_WDATA) begin
                            n_header_open = 1'b0;
                            if (n_err != 4'd0) begin
                                w_res = '{status: n_err, done_res: 1'b1, byte_count: 17'd0};
                            end else begin
                                n_resp_pending = 1'b1;
                                w_res = '{status: ST_OK, done_res: 1'b1,
                                          byte_count: n_call_total};
                            end
                            n_phase = PH_IDLE;
                        end else begin
                            if (n_err != 4'd0) begin
                                w_res   = '{status: n_err, done_res: 1'b1, byte_count: 17'd0};
                                n_phase = PH_IDLE;
                            end else if (i_cfg.ack_wait) begin
                                n_retry = '0;
                                w_res   = '{status: ST_WAIT_ACK, done_res: 1'b0,
                                            byte_count: 17'd0};
                                n_phase = PH_ACK;
                            end else begin
                                w_res   = '{status: ST_OK, done_res: 1'b1,
                                            byte_count: n_call_total};
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                end
                KIND_HDR_REPLY: begin
                    if (r_phase == PH_HREPLY) begin
                        if (w_b == HDR_ACK) begin
                            n_out_len     = r_held[15:0];
                            n_back_len    = r_held[31:16];
                            n_header_open = 1'b1;
                            w_res = '{status: ST_OK, done_res: 1'b1, byte_count: 17'd7};
                        end else begin
                            w_res = '{status: ST_HDR_REPLY, done_res: 1'b1,
                                      byte_count: 17'd0};
                        end
                        n_phase = PH_IDLE;
                    end
                end
                KIND_ACK_REPLY: begin
                    if (r_phase == PH_ACK) begin
                        if (w_b == i_cfg.ack_expected) begin
                            w_res   = '{status: ST_OK, done_res: 1'b1,
                                        byte_count: r_call_total};
                            n_phase = PH_IDLE;
                        end else begin
                            n_retry = r_retry + 10'd1;
                            if (n_retry > i_cfg.ack_retry_limit) begin
                                w_res   = '{status: ST_ACK_FAIL, done_res: 1'b1,
                                            byte_count: 17'd0};
                                n_phase = PH_IDLE;
                            end else begin
                                w_res = '{status: ST_WAIT_ACK, done_res: 1'b0,
                                          byte_count: 17'd0};
                            end
                        end
                    end
                end
                KIND_RD_START: begin
                    if (r_phase == PH_IDLE) begin
                        if (w_len == 17'd0) begin
                            w_res = '{status: ST_OK, done_res: 1'b1, byte_count: 17'd0};
                        end else if (r_resp_pending) begin
                            if (w_len < w_need) begin
                                w_res = '{status: ST_SMALL, done_res: 1'b1,
                                          byte_count: 17'd0};
                            end else begin
                                n_resp_pending = 1'b0;
                                n_call_total   = w_need;
                                n_pos          = '0;
                                n_xor          = XOR_SEED;
                                n_err          = '0;
                                n_frame_len    = '0;
                                n_phase        = PH_READ;
                                w_res = '{status: ST_CONTINUE, done_res: 1'b0,
                                          byte_count: w_need};
                            end
                        end else if (r_header_open) begin
                            w_res = '{status: ST_BUSY, done_res: 1'b1, byte_count: 17'd0};
                        end else begin
                            // nothing framed outstanding: plain read
                            w_res = '{status: ST_OK, done_res: 1'b1, byte_count: w_len};
                        end
                    end
                end
                KIND_RD_BYTE: begin
                    if (r_phase == PH_READ) begin
                        if (r_pos == 17'd0) begin
                            if (w_b == RESP_NACK) begin
                                n_err = ST_NACK;
                            end else if (w_b != RESP_START) begin
                                n_err = ST_START;
                            end
                            n_xor = r_xor ^ w_b;
                        end else if (r_pos == 17'd1) begin
                            n_frame_len = {8'd0, w_b};
                            n_xor       = r_xor ^ w_b;
                        end else if (r_pos == 17'd2) begin
                            n_frame_len = {w_b, r_frame_len[7:0]};
                            n_xor       = r_xor ^ w_b;
                            if (n_frame_len > r_back_len && r_err == 4'd0) begin
                                n_err = ST_RESP_LEN;
                            end
                        end else if (r_err == 4'd0) begin
                            if (r_pos < 17'd3 + {1'b0, r_frame_len}) begin
                                n_xor = r_xor ^ w_b;
                            end else if (r_pos == 17'd3 + {1'b0, r_frame_len}
                                         && r_xor != w_b) begin
                                n_err = ST_RESP_CHK;
                            end
                        end
                        w_last = ({1'b0, r_pos} + 18'd1) == {1'b0, r_call_total};
                        if (!w_last) begin
                            n_pos = r_pos + 17'd1;
                        end else begin
                            if (n_err != 4'd0) begin
                                w_res = '{status: n_err, done_res: 1'b1, byte_count: 17'd0};
                            end else begin
                                w_res = '{status: ST_OK, done_res: 1'b1,
                                          byte_count: 17'd4 + {1'b0, n_frame_len}};
                            end
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    // unused kinds are ignored
                end
            endcase
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_header_open  <= 1'b0;
            r_resp_pending <= 1'b0;
            r_out_len      <= '0;
            r_back_len     <= '0;
            r_held         <= '0;
            r_pos          <= '0;
            r_xor          <= XOR_SEED;
            r_frame_len    <= '0;
            r_err          <= '0;
            r_retry        <= '0;
            r_call_total   <= '0;
        end else begin
            r_phase        <= n_phase;
            r_header_open  <= n_header_open;
            r_resp_pending <= n_resp_pending;
            r_out_len      <= n_out_len;
            r_back_len     <= n_back_len;
            r_held         <= n_held;
            r_pos          <= n_pos;
            r_xor          <= n_xor;
            r_frame_len    <= n_frame_len;
            r_err          <= n_err;
            r_retry        <= n_retry;
            r_call_total   <= n_call_total;
        end
    end

    // data phase only exists under an open header
    a_data_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WDATA |-> r_header_open)
        else $error("data phase without open header");

    // a framed read consumes the pending response
    a_read_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_READ |-> !r_resp_pending)
        else $error("response still pending during read");

    // header reply wait is only reached with a clean header
    a_hreply_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HREPLY |-> r_err == 4'd0)
        else $error("header reply wait with latched error");

    // byte position stays inside the call
    a_pos_in_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WHDR || r_phase == PH_WDATA || r_phase == PH_WRAW
         || r_phase == PH_READ) |-> r_pos < r_call_total)
        else $error("byte position past end of call");

endmodule

// ----- sv/spi_framed_transaction_checker.sv -----
// An accepted item passes through the input register and then the result register
// to o_out_*. Throughput: one item per cycle while the output is not stalled; the
// input register and the result register each free up in the cycle their item
// moves on, so a stalled output still leaves room for one more accepted item.
// Reset (i_rst_n low, synchronous): idle phase, no transaction open, registers
// back to ack off, ack byte 0x06, retry limit 3; both stages empty.
module spi_framed_transaction_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sftc_pkg::t_in_item                  i_in_item,
    // result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sftc_pkg::t_out_item                 o_out_item,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [sftc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sftc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sftc_pkg::*;

    // Stage 1: input register
    logic      r_in_valid;
    t_in_item  r_in_item;
    // Stage 2: result register
    logic      r_out_valid;
    t_out_item r_out_item;
    // Configuration registers
    t_cfg      r_cfg;

    t_out_item w_result;
    logic      w_advance;
    logic      w_in_take;

    // The held item moves on when the result slot is empty or being drained.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Verdict logic; state commits on the same edge the result is captured.
    sftc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration writes; out-of-range retry limits and unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_wait        <= 1'b0;
            r_cfg.ack_expected    <= ACK_EXPECTED_RST;
            r_cfg.ack_retry_limit <= ACK_RETRY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACK_WAIT:     r_cfg.ack_wait     <= i_cfg_data[0];
                CFG_ACK_EXPECTED: r_cfg.ack_expected <= i_cfg_data[7:0];
                CFG_ACK_RETRY: begin
                    if (i_cfg_data[9:0] <= RETRY_MAX) begin
                        r_cfg.ack_retry_limit <= i_cfg_data[9:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Error verdicts are always final and carry no byte count.
    a_error_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status >= ST_HDR_CHK && r_out_item.status <= ST_ACK_FAIL)
        |-> (r_out_item.done_res && r_out_item.byte_count == 17'd0))
        else $error("error verdict not final or with count");

    // Continue and wait codes never close a call.
    a_wait_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_item.status == ST_CONTINUE
                         || r_out_item.status == ST_WAIT_HDR
                         || r_out_item.status == ST_WAIT_ACK))
        |-> !r_out_item.done_res)
        else $error("non-final status marked done");

    // A stalled result item stays offered and unchanged.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_item)))
        else $error("result item changed while stalled");

endmodule
